// File: rtl/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// Shared types and constants for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xmr_pkg;

    localparam int CAPACITY_BITS = 24;

    localparam int ADDR_W = 24;
    localparam int SIZE_W = 25;
    localparam int CNT_W  = 24;

    // Receive buffer size in bytes, limited to 2^24
    localparam logic [SIZE_W:0] CapBytes =
        (CAPACITY_BITS > 24) ? (SIZE_W + 1)'(2 ** 24) : (SIZE_W + 1)'(2 ** CAPACITY_BITS);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [7:0] BLOCK_LEN   = 8'd128;
    localparam logic [6:0] LAST_INDEX  = 7'd127;
    localparam logic [CNT_W-1:0] NAK_DEFAULT = 24'd2000000;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_CANCEL   = 3'd2;
    localparam logic [2:0] ST_ERROR    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Configuration register indexes
    localparam logic REG_NAK_INTERVAL = 1'b0;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_data;
        logic [2:0]        status;
        logic [SIZE_W-1:0] total_size;
    } result_t;

endpackage

// File: rtl/xmr_if.sv
// ----------------------------------------------------------------------------
// xmr_if
// Valid/ready channels for received items and for results.
// ----------------------------------------------------------------------------
interface xmr_rx_if;
    import xmr_pkg::*;

    logic     valid;
    logic     ready;
    rx_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface xmr_res_if;
    import xmr_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/xmodem_checksum_receiver_top.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_top
// XMODEM receiver, 8-bit checksum, 128-byte blocks, one result per request.
// ----------------------------------------------------------------------------
// Takes one request (received byte or idle poll tick) every clock cycle while
// the result side does not stall and gives exactly one result per request. A
// request is captured in an input register and then processed into the result
// register, from which its result is offered. When the result side stalls, the
// input register holds one more request and the input then stalls too. The
// protocol state (phase, block number, offset, running checksum, idle counter)
// is updated when a request is processed, in the same cycle as the result
// register is loaded. nak_interval is written through the APB port at byte
// address 0 and should only be changed while the receiver is idle.
module xmodem_checksum_receiver_top (
    input  logic                   clk,
    input  logic                   rst_n,
    xmr_rx_if.sink                 rx,
    xmr_res_if.source              res,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import xmr_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NUMBER = 3'd1,
        PH_COMPL  = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    // Input register
    logic       in_valid_reg;
    rx_item_t   in_item_reg;

    // Result register
    logic       out_valid_reg;
    result_t    out_item_reg;
    result_t    out_item_next;

    // Protocol state
    phase_t             phase_reg,    phase_next;
    logic               started_reg,  started_next;
    logic [7:0]         expect_reg,   expect_next;
    logic [6:0]         index_reg,    index_next;
    logic [7:0]         sum_reg,      sum_next;
    logic [SIZE_W-1:0]  size_reg,     size_next;
    logic [CNT_W-1:0]   idle_reg,     idle_next;
    logic [2:0]         status_reg,   status_next;
    logic [CNT_W-1:0]   nak_interval_reg;

    logic               advance;
    logic               process;
    logic               rx_fire;
    logic               cfg_write;
    logic [CNT_W-1:0]   idle_inc;
    logic [SIZE_W:0]    size_end;

    assign advance = !out_valid_reg || res.ready;
    assign process = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;
    assign rx_fire = rx.valid && rx.ready;

    assign res.valid   = out_valid_reg;
    assign res.payload = out_item_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NAK_INTERVAL);
    assign prdata    = (paddr[2] == REG_NAK_INTERVAL) ? {8'd0, nak_interval_reg} : 32'd0;

    assign idle_inc = idle_reg + CNT_W'(1);
    assign size_end = {1'b0, size_reg} + (SIZE_W + 1)'(BLOCK_LEN);

    always_comb
    begin
        phase_next    = phase_reg;
        started_next  = started_reg;
        expect_next   = expect_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        size_next     = size_reg;
        idle_next     = idle_reg;
        status_next   = status_reg;
        out_item_next = '0;

        if (process && phase_reg != PH_STOP && status_reg == ST_BUSY)
        begin
            if (!in_item_reg.byte_valid)
            begin
                // poll tick: only counts before the first block header
                if (phase_reg == PH_HEADER && !started_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= nak_interval_reg)
                    begin
                        idle_next              = '0;
                        out_item_next.tx_valid = 1'b1;
                        out_item_next.tx_byte  = CH_NAK;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (!started_reg)
                        begin
                            idle_next = '0;
                        end
                        if (in_item_reg.rx_byte == CH_EOT)
                        begin
                            out_item_next.tx_valid = 1'b1;
                            out_item_next.tx_byte  = CH_ACK;
                            status_next            = ST_DONE;
                            phase_next             = PH_STOP;
                        end
                        else if (in_item_reg.rx_byte == CH_CAN)
                        begin
                            status_next = ST_CANCEL;
                            phase_next  = PH_STOP;
                        end
                        else if (in_item_reg.rx_byte == CH_SOH)
                        begin
                            started_next = 1'b1;
                            phase_next   = PH_NUMBER;
                        end
                        else if (started_reg)
                        begin
                            status_next = ST_ERROR;
                            phase_next  = PH_STOP;
                        end
                    end
                    PH_NUMBER:
                    begin
                        if (in_item_reg.rx_byte != expect_reg)
                        begin
                            out_item_next.tx_valid = 1'b1;
                            out_item_next.tx_byte  = CH_NAK;
                            phase_next             = PH_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_COMPL;
                        end
                    end
                    PH_COMPL:
                    begin
                        if ((expect_reg ^ in_item_reg.rx_byte) != 8'hFF)
                        begin
                            out_item_next.tx_valid = 1'b1;
                            out_item_next.tx_byte  = CH_NAK;
                            phase_next             = PH_HEADER;
                        end
                        else if (size_end > CapBytes)
                        begin
                            status_next = ST_OVERFLOW;
                            phase_next  = PH_STOP;
                        end
                        else
                        begin
                            index_next = '0;
                            sum_next   = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        out_item_next.write_valid = 1'b1;
                        out_item_next.write_addr  =
                            size_reg[ADDR_W-1:0] + ADDR_W'(index_reg);
                        out_item_next.write_data  = in_item_reg.rx_byte;
                        sum_next = sum_reg + in_item_reg.rx_byte;
                        if (index_reg == LAST_INDEX)
                        begin
                            index_next = '0;
                            phase_next = PH_CSUM;
                        end
                        else
                        begin
                            index_next = index_reg + 7'd1;
                        end
                    end
                    PH_CSUM:
                    begin
                        out_item_next.tx_valid = 1'b1;
                        if (sum_reg == in_item_reg.rx_byte)
                        begin
                            expect_next           = expect_reg + 8'd1;
                            size_next             = size_reg + SIZE_W'(BLOCK_LEN);
                            out_item_next.tx_byte = CH_ACK;
                        end
                        else
                        begin
                            out_item_next.tx_byte = CH_NAK;
                        end
                        phase_next = PH_HEADER;
                    end
                    default:
                    begin
                        status_next = ST_ERROR;
                        phase_next  = PH_STOP;
                    end
                endcase
            end
        end

        out_item_next.status     = status_next;
        out_item_next.total_size = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_HEADER;
            started_reg      <= 1'b0;
            expect_reg       <= 8'd1;
            index_reg        <= '0;
            sum_reg          <= '0;
            size_reg         <= '0;
            idle_reg         <= '0;
            status_reg       <= ST_BUSY;
            nak_interval_reg <= NAK_DEFAULT;
        end
        else
        begin
            if (cfg_write)
            begin
                nak_interval_reg <= pwdata[CNT_W-1:0];
            end

            if (rx_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            phase_reg   <= phase_next;
            started_reg <= started_next;
            expect_reg  <= expect_next;
            index_reg   <= index_next;
            sum_reg     <= sum_next;
            size_reg    <= size_next;
            idle_reg    <= idle_next;
            status_reg  <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_item_reg <= rx.payload;
        end
        if (process)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // A data write never carries a reply byte
    a_write_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.write_valid |-> !out_item_reg.tx_valid)
        else $error("reply byte issued together with a data write");

    // Terminal status holds until reset
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != ST_BUSY |=> status_reg == $past(status_reg))
        else $error("terminal status changed");

    // Stop phase and terminal status go together
    a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOP) == (status_reg != ST_BUSY))
        else $error("stop phase and status disagree");

    // Accepted size moves in whole blocks
    a_size_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg[6:0] == 7'd0)
        else $error("accepted size not block aligned");

endmodule
